### design/kce_pkg.sv
package kce_pkg;

   localparam int COORD_W = 16;
   localparam int CSR_IDX_W = 4;
   localparam int CSR_DATA_W = 13;

   localparam logic [1:0] MODE_LOAD = 2'd0;
   localparam logic [1:0] MODE_RUN = 2'd1;
   localparam logic [1:0] MODE_READ_ASSIGN = 2'd2;
   localparam logic [1:0] MODE_READ_CENTROID = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_POINT_COUNT = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DIMENSION_COUNT = 4'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CLUSTER_COUNT = 4'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ITERATION_LIMIT = 4'd3;

   typedef struct packed {
      logic [1:0] mode;
      logic [11:0] point_index;
      logic [5:0] dim_index;
      logic [6:0] cluster_index;
      logic signed [15:0] coord_value;
   } req_type;

   typedef struct packed {
      logic [6:0] cluster_id;
      logic signed [15:0] centroid_value;
      logic [7:0] iterations;
      logic converged;
   } rsp_type;

   // control that travels with one coordinate through the distance cells
   typedef struct packed {
      logic valid;
      logic first;
      logic last;
   } dist_ctl_type;

endpackage

### design/kce_dist_pipe.sv
module kce_dist_pipe #(
   parameter int TAG_W = 7,
   parameter int DIST_W = 41
) (
   input logic clock,
   input logic reset,
   input kce_pkg::dist_ctl_type in_ctl,
   input logic [TAG_W-1:0] in_tag,
   input logic signed [kce_pkg::COORD_W-1:0] in_a,
   input logic signed [kce_pkg::COORD_W-1:0] in_b,
   output logic out_valid,
   output logic [TAG_W-1:0] out_tag,
   output logic [DIST_W-1:0] out_dist
);
   import kce_pkg::*;

   localparam int DIFF_W = COORD_W + 1;

   // cell 1: difference, cell 2: square, cell 3: running sum
   dist_ctl_type c1_ctl_ff, c2_ctl_ff, c3_ctl_ff;
   logic [TAG_W-1:0] c1_tag_ff, c2_tag_ff, c3_tag_ff;
   logic signed [DIFF_W-1:0] diff_ff;
   logic signed [2*DIFF_W-1:0] sq_ff;
   logic [DIST_W-1:0] acc_ff, acc_in;

   always_comb begin
      if (c2_ctl_ff.first) begin
         acc_in = DIST_W'(sq_ff);
      end else begin
         acc_in = acc_ff + DIST_W'(sq_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c1_ctl_ff <= '0;
         c2_ctl_ff <= '0;
         c3_ctl_ff <= '0;
      end else begin
         c1_ctl_ff <= in_ctl;
         c2_ctl_ff <= c1_ctl_ff;
         c3_ctl_ff <= c2_ctl_ff;
      end
      c1_tag_ff <= in_tag;
      c2_tag_ff <= c1_tag_ff;
      c3_tag_ff <= c2_tag_ff;
      diff_ff <= DIFF_W'(in_a) - DIFF_W'(in_b);
      sq_ff <= diff_ff * diff_ff;
      if (c2_ctl_ff.valid) begin
         acc_ff <= acc_in;
      end
   end

   assign out_valid = c3_ctl_ff.valid && c3_ctl_ff.last;
   assign out_tag = c3_tag_ff;
   assign out_dist = acc_ff;

endmodule

### design/kce_divider.sv
module kce_divider #(
   parameter int NUM_W = 29,
   parameter int DEN_W = 13
) (
   input logic clock,
   input logic reset,
   input logic start,
   input logic signed [NUM_W-1:0] num,
   input logic [DEN_W-1:0] den,
   output logic done,
   output logic signed [NUM_W-1:0] quo
);
   import kce_pkg::*;

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic act_ff, done_ff, neg_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [DEN_W-1:0] rem_ff, den_ff;
   logic [NUM_W-1:0] q_ff;
   logic [DEN_W:0] sh;
   logic ge;

   // restoring division on magnitudes, one quotient bit a cycle
   assign sh = {rem_ff, q_ff[NUM_W-1]};
   assign ge = sh >= {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         act_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            act_ff <= 1'b1;
         end else if (act_ff && cnt_ff == CNT_W'(1)) begin
            act_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
      if (start) begin
         neg_ff <= num[NUM_W-1];
         q_ff <= num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
         rem_ff <= '0;
         den_ff <= den;
         cnt_ff <= CNT_W'(NUM_W);
      end else if (act_ff) begin
         rem_ff <= ge ? DEN_W'(sh - {1'b0, den_ff}) : DEN_W'(sh);
         q_ff <= {q_ff[NUM_W-2:0], ge};
         cnt_ff <= cnt_ff - CNT_W'(1);
      end
   end

   assign done = done_ff;
   assign quo = neg_ff ? -$signed(q_ff) : $signed(q_ff);

endmodule

### design/kmeans_cluster_engine_core.sv
// Lloyd k-means engine for Q8.8 points. For loads (mode 0) and reads of an
// assignment (mode 2) or a centroid coordinate (mode 3), rsp_strobe is
// high in the cycle after the start transfer and busy drops in the cycle
// after that. A run (mode 1) holds busy until it is done: a sweep clears the
// assignments, seeding copies the first k points to the centroids, each
// pass sends every point through the distance cell chain against every
// centroid, and an update sums each cluster's points and divides each sum
// of a non-empty cluster by its count in the serial divider, where SUM_W is
// the width of a centroid sum. The run's result strobes after the last pass
// in which no point moved, or once the iteration limit is reached.
// After reset the engine clears the assignment memory with busy high;
// configuration writes are taken at any time.
// The receiver cannot stall: every result is shown for exactly one cycle.
module kmeans_cluster_engine_core #(
   parameter int MAX_POINTS = 4096,
   parameter int MAX_DIMS = 64,
   parameter int MAX_CLUSTERS = 128
) (
   input logic clock,
   input logic reset,
   input logic start,
   output logic busy,
   input kce_pkg::req_type req_data,
   output logic rsp_strobe,
   output kce_pkg::rsp_type rsp_data,
   input logic csr_valid,
   output logic csr_ready,
   input logic [kce_pkg::CSR_IDX_W-1:0] csr_index,
   input logic [kce_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import kce_pkg::*;

   // index widths (one bit minimum) and count widths (hold the maximum)
   localparam int PIW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
   localparam int DIW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
   localparam int KIW = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
   localparam int PAW = (MAX_POINTS * MAX_DIMS > 1) ? $clog2(MAX_POINTS * MAX_DIMS) : 1;
   localparam int CAW = (MAX_CLUSTERS * MAX_DIMS > 1) ?
                        $clog2(MAX_CLUSTERS * MAX_DIMS) : 1;
   localparam int NPW = $clog2(MAX_POINTS + 1);
   localparam int NDW = $clog2(MAX_DIMS + 1);
   localparam int NKW = $clog2(MAX_CLUSTERS + 1);
   localparam int SUM_W = COORD_W + NPW;
   localparam int DIST_W = 2 * (COORD_W + 1) + NDW;

   typedef enum logic [20:0] {
      S_CLR        = 21'd1 << 0,
      S_IDLE       = 21'd1 << 1,
      S_RESP       = 21'd1 << 2,
      S_SEED_RD    = 21'd1 << 3,
      S_SEED_WR    = 21'd1 << 4,
      S_PASS       = 21'd1 << 5,
      S_ISSUE      = 21'd1 << 6,
      S_DRAIN      = 21'd1 << 7,
      S_PT_RD      = 21'd1 << 8,
      S_PT_WR      = 21'd1 << 9,
      S_UCLR       = 21'd1 << 10,
      S_ACC_RD     = 21'd1 << 11,
      S_ACC_CNT    = 21'd1 << 12,
      S_ACC_CINC   = 21'd1 << 13,
      S_ACC_DIM_RD = 21'd1 << 14,
      S_ACC_DIM_WR = 21'd1 << 15,
      S_DIV_RD     = 21'd1 << 16,
      S_DIV_CHK    = 21'd1 << 17,
      S_DIV_SRD    = 21'd1 << 18,
      S_DIV_GO     = 21'd1 << 19,
      S_DIV_WAIT   = 21'd1 << 20
   } state_type;

   function automatic logic [PAW-1:0] pt_addr(input logic [PIW-1:0] p,
                                              input logic [DIW-1:0] d);
      return PAW'(PAW'(p) * PAW'(MAX_DIMS) + PAW'(d));
   endfunction

   function automatic logic [CAW-1:0] ce_addr(input logic [KIW-1:0] c,
                                              input logic [DIW-1:0] d);
      return CAW'(CAW'(c) * CAW'(MAX_DIMS) + CAW'(d));
   endfunction

   state_type state_ff, state_in;

   // configuration registers
   logic [12:0] pc_ff;
   logic [6:0] dc_ff;
   logic [7:0] cc_ff, il_ff;

   // run control
   logic run_ff, run_in;
   logic [NPW-1:0] np_ff, np_in;
   logic [NDW-1:0] n_ff, n_in;
   logic [NKW-1:0] k_ff, k_in;
   logic [PIW-1:0] pt_ff, pt_in;
   logic [DIW-1:0] ij_ff, ij_in;
   logic [KIW-1:0] ic_ff, ic_in;
   logic [7:0] pass_ff, pass_in;
   logic conv_ff, conv_in;
   logic moved_ff, moved_in;
   logic [KIW-1:0] best_ff, best_in;
   logic [DIST_W-1:0] best_d_ff, best_d_in;
   logic [KIW-1:0] acc_c_ff, acc_c_in;
   logic [NPW-1:0] div_cnt_ff, div_cnt_in;
   logic [1:0] mode_ff, mode_in;
   logic ok_ff, ok_in;

   // memories and their ports
   logic signed [COORD_W-1:0] pt_mem [MAX_POINTS*MAX_DIMS];
   logic signed [COORD_W-1:0] ce_mem [MAX_CLUSTERS*MAX_DIMS];
   logic signed [SUM_W-1:0] sm_mem [MAX_CLUSTERS*MAX_DIMS];
   logic [NPW-1:0] cn_mem [MAX_CLUSTERS];
   logic [KIW-1:0] as_mem [MAX_POINTS];

   logic pt_we, ce_we, sm_we, cn_we, as_we;
   logic [PAW-1:0] pt_ra, pt_wa;
   logic [CAW-1:0] ce_ra, ce_wa, sm_ra, sm_wa;
   logic [KIW-1:0] cn_ra, cn_wa;
   logic [PIW-1:0] as_ra, as_wa;
   logic signed [COORD_W-1:0] pt_wd, ce_wd, pt_rd_ff, ce_rd_ff;
   logic signed [SUM_W-1:0] sm_wd, sm_rd_ff;
   logic [NPW-1:0] cn_wd, cn_rd_ff;
   logic [KIW-1:0] as_wd, as_rd_ff;

   // distance cell chain
   dist_ctl_type iss_ctl, iss_ctl_ff;
   logic [KIW-1:0] iss_tag_ff;
   logic dist_valid;
   logic [KIW-1:0] dist_tag;
   logic [DIST_W-1:0] dist_val;

   // divider
   logic div_start, div_done;
   logic signed [SUM_W-1:0] div_quo;

   logic accept, j_last, c_last, p_last, differ;
   logic pi_ok, di_ok, ci_ok;
   logic [NPW-1:0] np_clamp;
   logic [NKW-1:0] k_clamp;

   assign accept = start && !busy;
   assign busy = (state_ff != S_IDLE);
   assign csr_ready = 1'b1;

   assign j_last = (NDW'(ij_ff) + NDW'(1)) == n_ff;
   assign c_last = (NKW'(ic_ff) + NKW'(1)) == k_ff;
   assign p_last = (NPW'(pt_ff) + NPW'(1)) == np_ff;
   assign differ = as_rd_ff != best_ff;

   assign pi_ok = 32'(req_data.point_index) < MAX_POINTS;
   assign di_ok = 32'(req_data.dim_index) < MAX_DIMS;
   assign ci_ok = 32'(req_data.cluster_index) < MAX_CLUSTERS;

   // clamp registers to the storage, then k to the point count
   always_comb begin
      np_clamp = (32'(pc_ff) > MAX_POINTS) ? NPW'(MAX_POINTS) : NPW'(pc_ff);
      k_clamp = (32'(cc_ff) > MAX_CLUSTERS) ? NKW'(MAX_CLUSTERS) : NKW'(cc_ff);
      if (32'(k_clamp) > 32'(np_clamp)) begin
         k_clamp = NKW'(np_clamp);
      end
   end

   always_comb begin
      state_in = state_ff;
      run_in = run_ff;
      np_in = np_ff;
      n_in = n_ff;
      k_in = k_ff;
      pt_in = pt_ff;
      ij_in = ij_ff;
      ic_in = ic_ff;
      pass_in = pass_ff;
      conv_in = conv_ff;
      moved_in = moved_ff;
      best_in = best_ff;
      best_d_in = best_d_ff;
      acc_c_in = acc_c_ff;
      div_cnt_in = div_cnt_ff;
      mode_in = mode_ff;
      ok_in = ok_ff;

      pt_we = 1'b0;
      pt_wa = pt_addr(PIW'(req_data.point_index), DIW'(req_data.dim_index));
      pt_wd = req_data.coord_value;
      pt_ra = pt_addr(pt_ff, ij_ff);
      ce_we = 1'b0;
      ce_wa = ce_addr(ic_ff, ij_ff);
      ce_wd = pt_rd_ff;
      ce_ra = ce_addr(ic_ff, ij_ff);
      sm_we = 1'b0;
      sm_wa = ce_addr(acc_c_ff, ij_ff);
      sm_wd = sm_rd_ff + SUM_W'(pt_rd_ff);
      sm_ra = ce_addr(acc_c_ff, ij_ff);
      cn_we = 1'b0;
      cn_wa = acc_c_ff;
      cn_wd = cn_rd_ff + NPW'(1);
      cn_ra = ic_ff;
      as_we = 1'b0;
      as_wa = pt_ff;
      as_wd = '0;
      as_ra = pt_ff;

      iss_ctl = '0;
      div_start = 1'b0;

      // nearest centroid so far; a strict compare keeps the lower index on a tie
      if (dist_valid && (dist_tag == '0 || dist_val < best_d_ff)) begin
         best_in = dist_tag;
         best_d_in = dist_val;
      end

      case (state_ff)
         S_CLR: begin
            as_we = 1'b1;
            if (pt_ff == PIW'(MAX_POINTS - 1)) begin
               pt_in = '0;
               ic_in = '0;
               ij_in = '0;
               if (!run_ff) begin
                  state_in = S_IDLE;
               end else if (np_ff == '0 || n_ff == '0 || k_ff == '0) begin
                  state_in = S_RESP;
               end else begin
                  state_in = S_SEED_RD;
               end
            end else begin
               pt_in = pt_ff + PIW'(1);
            end
         end
         S_IDLE: begin
            if (accept) begin
               mode_in = req_data.mode;
               state_in = S_RESP;
               case (req_data.mode)
                  MODE_LOAD: begin
                     pt_we = pi_ok && di_ok;
                  end
                  MODE_RUN: begin
                     run_in = 1'b1;
                     np_in = np_clamp;
                     n_in = (32'(dc_ff) > MAX_DIMS) ? NDW'(MAX_DIMS) : NDW'(dc_ff);
                     k_in = k_clamp;
                     pass_in = '0;
                     conv_in = 1'b0;
                     pt_in = '0;
                     state_in = S_CLR;
                  end
                  MODE_READ_ASSIGN: begin
                     ok_in = pi_ok;
                     as_ra = PIW'(req_data.point_index);
                  end
                  MODE_READ_CENTROID: begin
                     ok_in = ci_ok && di_ok;
                     ce_ra = ce_addr(KIW'(req_data.cluster_index), DIW'(req_data.dim_index));
                  end
                  default: begin
                     ok_in = 1'b0;
                  end
               endcase
            end
         end
         S_RESP: begin
            run_in = 1'b0;
            state_in = S_IDLE;
         end
         S_SEED_RD: begin
            pt_ra = pt_addr(PIW'(ic_ff), ij_ff);
            state_in = S_SEED_WR;
         end
         S_SEED_WR: begin
            ce_we = 1'b1;
            state_in = S_SEED_RD;
            if (j_last) begin
               ij_in = '0;
               if (c_last) begin
                  state_in = S_PASS;
               end else begin
                  ic_in = ic_ff + KIW'(1);
               end
            end else begin
               ij_in = ij_ff + DIW'(1);
            end
         end
         S_PASS: begin
            pt_in = '0;
            ic_in = '0;
            ij_in = '0;
            moved_in = 1'b0;
            state_in = (pass_ff < il_ff) ? S_ISSUE : S_RESP;
         end
         S_ISSUE: begin
            iss_ctl.valid = 1'b1;
            iss_ctl.first = (ij_ff == '0);
            iss_ctl.last = j_last;
            if (j_last) begin
               ij_in = '0;
               if (c_last) begin
                  state_in = S_DRAIN;
               end else begin
                  ic_in = ic_ff + KIW'(1);
               end
            end else begin
               ij_in = ij_ff + DIW'(1);
            end
         end
         S_DRAIN: begin
            if (dist_valid && dist_tag == KIW'(k_ff - NKW'(1))) begin
               state_in = S_PT_RD;
            end
         end
         S_PT_RD: begin
            state_in = S_PT_WR;
         end
         S_PT_WR: begin
            as_we = differ;
            as_wd = best_ff;
            moved_in = moved_ff || differ;
            ic_in = '0;
            ij_in = '0;
            if (p_last) begin
               pt_in = '0;
               pass_in = pass_ff + 8'd1;
               if (!(moved_ff || differ)) begin
                  conv_in = 1'b1;
                  state_in = S_RESP;
               end else begin
                  state_in = S_UCLR;
               end
            end else begin
               pt_in = pt_ff + PIW'(1);
               state_in = S_ISSUE;
            end
         end
         S_UCLR: begin
            sm_we = 1'b1;
            sm_wa = ce_addr(ic_ff, ij_ff);
            sm_wd = '0;
            cn_we = (ij_ff == '0);
            cn_wa = ic_ff;
            cn_wd = '0;
            if (j_last) begin
               ij_in = '0;
               if (c_last) begin
                  ic_in = '0;
                  state_in = S_ACC_RD;
               end else begin
                  ic_in = ic_ff + KIW'(1);
               end
            end else begin
               ij_in = ij_ff + DIW'(1);
            end
         end
         S_ACC_RD: begin
            state_in = S_ACC_CNT;
         end
         S_ACC_CNT: begin
            acc_c_in = as_rd_ff;
            cn_ra = as_rd_ff;
            state_in = S_ACC_CINC;
         end
         S_ACC_CINC: begin
            cn_we = 1'b1;
            ij_in = '0;
            state_in = S_ACC_DIM_RD;
         end
         S_ACC_DIM_RD: begin
            state_in = S_ACC_DIM_WR;
         end
         S_ACC_DIM_WR: begin
            sm_we = 1'b1;
            state_in = S_ACC_DIM_RD;
            if (j_last) begin
               ij_in = '0;
               if (p_last) begin
                  pt_in = '0;
                  ic_in = '0;
                  state_in = S_DIV_RD;
               end else begin
                  pt_in = pt_ff + PIW'(1);
                  state_in = S_ACC_RD;
               end
            end else begin
               ij_in = ij_ff + DIW'(1);
            end
         end
         S_DIV_RD: begin
            state_in = S_DIV_CHK;
         end
         S_DIV_CHK: begin
            div_cnt_in = cn_rd_ff;
            ij_in = '0;
            if (cn_rd_ff != '0) begin
               state_in = S_DIV_SRD;
            end else if (c_last) begin
               state_in = S_PASS;
            end else begin
               ic_in = ic_ff + KIW'(1);
               state_in = S_DIV_RD;
            end
         end
         S_DIV_SRD: begin
            sm_ra = ce_addr(ic_ff, ij_ff);
            state_in = S_DIV_GO;
         end
         S_DIV_GO: begin
            div_start = 1'b1;
            state_in = S_DIV_WAIT;
         end
         S_DIV_WAIT: begin
            if (div_done) begin
               ce_we = 1'b1;
               ce_wd = COORD_W'(div_quo);
               if (j_last) begin
                  ij_in = '0;
                  if (c_last) begin
                     state_in = S_PASS;
                  end else begin
                     ic_in = ic_ff + KIW'(1);
                     state_in = S_DIV_RD;
                  end
               end else begin
                  ij_in = ij_ff + DIW'(1);
                  state_in = S_DIV_SRD;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLR;
         run_ff <= 1'b0;
         pt_ff <= '0;
         ij_ff <= '0;
         ic_ff <= '0;
         pass_ff <= '0;
         conv_ff <= 1'b0;
         moved_ff <= 1'b0;
         iss_ctl_ff <= '0;
         pc_ff <= '0;
         dc_ff <= 7'd1;
         cc_ff <= 8'd1;
         il_ff <= 8'd50;
      end else begin
         state_ff <= state_in;
         run_ff <= run_in;
         pt_ff <= pt_in;
         ij_ff <= ij_in;
         ic_ff <= ic_in;
         pass_ff <= pass_in;
         conv_ff <= conv_in;
         moved_ff <= moved_in;
         iss_ctl_ff <= iss_ctl;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_POINT_COUNT: pc_ff <= csr_wdata;
               CSR_DIMENSION_COUNT: dc_ff <= csr_wdata[6:0];
               CSR_CLUSTER_COUNT: cc_ff <= csr_wdata[7:0];
               CSR_ITERATION_LIMIT: il_ff <= csr_wdata[7:0];
               default: begin
               end
            endcase
         end
      end
      np_ff <= np_in;
      n_ff <= n_in;
      k_ff <= k_in;
      best_ff <= best_in;
      best_d_ff <= best_d_in;
      acc_c_ff <= acc_c_in;
      div_cnt_ff <= div_cnt_in;
      mode_ff <= mode_in;
      ok_ff <= ok_in;
      iss_tag_ff <= ic_ff;
   end

   // memories: one write and one registered read port each
   always_ff @(posedge clock) begin
      if (pt_we) begin
         pt_mem[pt_wa] <= pt_wd;
      end
      pt_rd_ff <= pt_mem[pt_ra];
   end

   always_ff @(posedge clock) begin
      if (ce_we) begin
         ce_mem[ce_wa] <= ce_wd;
      end
      ce_rd_ff <= ce_mem[ce_ra];
   end

   always_ff @(posedge clock) begin
      if (sm_we) begin
         sm_mem[sm_wa] <= sm_wd;
      end
      sm_rd_ff <= sm_mem[sm_ra];
   end

   always_ff @(posedge clock) begin
      if (cn_we) begin
         cn_mem[cn_wa] <= cn_wd;
      end
      cn_rd_ff <= cn_mem[cn_ra];
   end

   always_ff @(posedge clock) begin
      if (as_we) begin
         as_mem[as_wa] <= as_wd;
      end
      as_rd_ff <= as_mem[as_ra];
   end

   // point and centroid words meet the tag in the cycle after issue
   kce_dist_pipe #(
      .TAG_W(KIW),
      .DIST_W(DIST_W)
   ) u_dist (
      .clock(clock),
      .reset(reset),
      .in_ctl(iss_ctl_ff),
      .in_tag(iss_tag_ff),
      .in_a(pt_rd_ff),
      .in_b(ce_rd_ff),
      .out_valid(dist_valid),
      .out_tag(dist_tag),
      .out_dist(dist_val)
   );

   kce_divider #(
      .NUM_W(SUM_W),
      .DEN_W(NPW)
   ) u_div (
      .clock(clock),
      .reset(reset),
      .start(div_start),
      .num(sm_rd_ff),
      .den(div_cnt_ff),
      .done(div_done),
      .quo(div_quo)
   );

   // result: read data only for an in-range read of its own mode
   assign rsp_strobe = (state_ff == S_RESP);
   always_comb begin
      rsp_data.cluster_id = (mode_ff == MODE_READ_ASSIGN && ok_ff) ? 7'(as_rd_ff) : 7'd0;
      rsp_data.centroid_value = (mode_ff == MODE_READ_CENTROID && ok_ff) ?
                                ce_rd_ff : 16'sd0;
      rsp_data.iterations = pass_ff;
      rsp_data.converged = conv_ff;
   end

   // a result lasts one cycle
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe) else $error("rsp_strobe held");

   // an accepted command always makes the engine busy
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy) else $error("not busy after start transfer");

   // the divider only finishes while a quotient is awaited
   a_div_owner: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == S_DIV_WAIT) else $error("stray divider result");

endmodule
